>>> design/seirs_pkg.sv
// shared types, constants and threshold table for the seirs agent grid update
`default_nettype none
package seirs_pkg;

   localparam int GRID_SIDE_DEF    = 256;
   localparam int COUNT_BITS_DEF   = 16;
   localparam int NEIGHBOR_CAP_DEF = 63;

   localparam int            SIDE_REG_W = 9;
   localparam logic [8:0]    SIDE_RESET = 9'd256;
   localparam logic [31:0]   EXP_HALF_Q32 = 32'd2605029347;

   localparam logic       CMD_PLACE = 1'b0;
   localparam logic       CMD_STEP  = 1'b1;
   localparam logic [1:0] ST_S = 2'd0;
   localparam logic [1:0] ST_E = 2'd1;
   localparam logic [1:0] ST_I = 2'd2;
   localparam logic [1:0] ST_R = 2'd3;

   localparam logic [2:0] REG_GRID_SIDE = 3'd0;

   typedef struct packed {
      logic        cmd;
      logic [1:0]  status;
      logic [15:0] days_in_status;
      logic [15:0] dur_exposed;
      logic [15:0] dur_infected;
      logic [15:0] dur_recovered;
      logic [7:0]  old_x;
      logic [7:0]  old_y;
      logic [7:0]  new_x;
      logic [7:0]  new_y;
      logic [31:0] draw_u;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  next_status;
      logic [15:0] next_time;
      logic [5:0]  infected_nearby;
      logic        got_exposed;
   } rsp_word_type;

   typedef enum logic [1:0] {
      ADDR_CLEAR,
      ADDR_OLD,
      ADDR_NEW,
      ADDR_NB
   } addr_sel_type;

   typedef enum logic [1:0] {
      WR_ZERO,
      WR_DEC,
      WR_INC
   } wr_sel_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_MOD,
      S_ROUTE,
      S_DEC_RD,
      S_DEC_WR,
      S_NB_RD,
      S_NB_ACC,
      S_DECIDE,
      S_INC_RD,
      S_INC_WR,
      S_DONE
   } state_type;

   typedef struct packed {
      logic         load;
      logic         mod_step;
      addr_sel_type addr_sel;
      logic         mem_we;
      wr_sel_type   wr_sel;
      logic         nb_rd;
      logic         clr_step;
      logic         decide;
      logic         out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic       clr_last;
      logic       mod_last;
      logic       nb_last;
      logic       is_place;
      logic [1:0] status_in;
      logic       next_inf;
      logic       out_free;
   } dp_status_type;

   typedef logic [31:0] thresh_tab_type [256];

   // exposure threshold 1 - exp(-0.5 n) in q0.32, built at elaboration
   function automatic thresh_tab_type build_thresh();
      thresh_tab_type tab;
      logic [64:0]    e;
      e = 65'd1 << 32;
      for (int n = 0; n < 256; n++) begin
         tab[n] = 32'((65'd1 << 32) - e);
         e = ((e * 65'(EXP_HALF_Q32)) + (65'd1 << 31)) >> 32;
      end
      return tab;
   endfunction

   localparam thresh_tab_type THRESH_TAB = build_thresh();

endpackage
`default_nettype wire

>>> design/seirs_agent_grid_update.sv
// top level of the seirs agent grid update: register port, controller and datapath
// One agent word updates one cell of a torus grid of infected counts held in a
// single-port memory. After reset the block sweeps all GRID_SIDE*GRID_SIDE cells
// to zero, one cell a cycle, and stalls the input meanwhile; register writes are
// taken at any time. Each word then passes through an accept state, eight steps in
// the four bit-serial remainder lanes that fold the coordinates into the side in
// use, a routing state, and then memory work on the single port: a read and a
// write to release an infected agent's old cell, nine reads plus an accumulate
// step for the capped 3x3 sum of a susceptible agent, a read and a write to enter
// an agent whose next status is infected into its new cell, plus a decide and a
// result state. The result waits in an output register, loaded once it is free,
// and the next word is taken in the cycle after that register is loaded.
`default_nettype none
module seirs_agent_grid_update
   import seirs_pkg::*;
#(
   parameter int GRID_SIDE    = GRID_SIDE_DEF,
   parameter int COUNT_BITS   = COUNT_BITS_DEF,
   parameter int NEIGHBOR_CAP = NEIGHBOR_CAP_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_word,
   input  wire logic         psel,
   input  wire logic         penable,
   input  wire logic         pwrite,
   input  wire logic [2:0]   paddr,
   input  wire logic [31:0]  pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   // grid side register, clamped in the datapath
   logic [SIDE_REG_W-1:0] grid_side_ff;
   logic                  reg_hit;

   assign reg_hit = (paddr[2] == REG_GRID_SIDE[2]);
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_side_ff <= SIDE_RESET;
      end else if (psel && penable && pwrite && pready && reg_hit) begin
         grid_side_ff <= pwdata[SIDE_REG_W-1:0];
      end
   end

   // read back the register at any address with paddr[2] low, zero elsewhere
   assign prdata = reg_hit ? 32'(grid_side_ff) : '0;

   dp_cmd_type    cmd;
   dp_status_type stat;

   // controller: sequences the clear sweep and each word's memory accesses
   seirs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: remainder lanes, count memory, sum, status update, output register
   seirs_dp #(
      .GRID_SIDE    (GRID_SIDE),
      .COUNT_BITS   (COUNT_BITS),
      .NEIGHBOR_CAP (NEIGHBOR_CAP)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_word  (req_word),
      .grid_side (grid_side_ff),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

`ifndef SYNTHESIS
   // one word at a time: after an accept the input stalls
   a_stall_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("word accepted while previous word in work");

   // a fresh exposure ends exposed or already infected
   a_exposed_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.got_exposed) |->
      (rsp_word.next_status == ST_E || rsp_word.next_status == ST_I))
      else $error("exposure flagged with wrong status");

   // a new result never appears while the input is open
   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without work in progress");
`endif

endmodule
`default_nettype wire

>>> design/seirs_ctrl.sv
// sequencing state machine for the seirs agent grid update
`default_nettype none
module seirs_ctrl
   import seirs_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire dp_status_type stat,
   output dp_cmd_type         cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.addr_sel = ADDR_CLEAR;
      cmd.wr_sel   = WR_ZERO;
      req_stall    = 1'b1;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.mem_we   = 1'b1;
            cmd.clr_step = 1'b1;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (stat.mod_last) state_in = S_ROUTE;
         end
         S_ROUTE: begin
            priority if (stat.is_place) state_in = S_DECIDE;
            else if (stat.status_in == ST_I) state_in = S_DEC_RD;
            else if (stat.status_in == ST_S) state_in = S_NB_RD;
            else state_in = S_DECIDE;
         end
         S_DEC_RD: begin
            cmd.addr_sel = ADDR_OLD;
            state_in     = S_DEC_WR;
         end
         S_DEC_WR: begin
            cmd.addr_sel = ADDR_OLD;
            cmd.mem_we   = 1'b1;
            cmd.wr_sel   = WR_DEC;
            state_in     = S_DECIDE;
         end
         S_NB_RD: begin
            cmd.addr_sel = ADDR_NB;
            cmd.nb_rd    = 1'b1;
            if (stat.nb_last) state_in = S_NB_ACC;
         end
         S_NB_ACC: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = S_DONE;
            if (stat.next_inf) state_in = S_INC_RD;
         end
         S_INC_RD: begin
            cmd.addr_sel = ADDR_NEW;
            state_in     = S_INC_WR;
         end
         S_INC_WR: begin
            cmd.addr_sel = ADDR_NEW;
            cmd.mem_we   = 1'b1;
            cmd.wr_sel   = WR_INC;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

>>> design/seirs_dp.sv
// datapath: coordinate reduction, count memory, neighborhood sum, status update
`default_nettype none
module seirs_dp
   import seirs_pkg::*;
#(
   parameter int GRID_SIDE    = GRID_SIDE_DEF,
   parameter int COUNT_BITS   = COUNT_BITS_DEF,
   parameter int NEIGHBOR_CAP = NEIGHBOR_CAP_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dp_cmd_type        cmd,
   output dp_status_type          stat,
   input  wire req_word_type      req_word,
   input  wire logic [SIDE_REG_W-1:0] grid_side,
   input  wire logic              rsp_stall,
   output logic                   rsp_valid,
   output rsp_word_type           rsp_word
);

   localparam int SIDE_W = $clog2(GRID_SIDE + 1);
   localparam int CELLS  = GRID_SIDE * GRID_SIDE;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CAP_W  = $clog2(NEIGHBOR_CAP + 1);
   localparam int TOT_W  = ((COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W) + 1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [SIDE_W-1:0] side, side_m1;

   always_comb begin
      if (grid_side < SIDE_REG_W'(3)) side = SIDE_W'(3);
      else if (32'(grid_side) > GRID_SIDE) side = SIDE_W'(GRID_SIDE);
      else side = SIDE_W'(grid_side);
      side_m1 = side - SIDE_W'(1);
   end

   req_word_type req_ff;

   // four remainder lanes: old x, old y, new x, new y
   logic [7:0]        coord_ff [4];
   logic [SIDE_W-1:0] rem_ff   [4];
   logic [SIDE_W-1:0] rem_in   [4];
   logic [2:0]        bit_cnt_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         logic [SIDE_W:0] trial;
         trial = {rem_ff[i], coord_ff[i][7]};
         if (trial >= {1'b0, side}) rem_in[i] = SIDE_W'(trial - {1'b0, side});
         else rem_in[i] = SIDE_W'(trial);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff      <= req_word;
         coord_ff[0] <= req_word.old_x;
         coord_ff[1] <= req_word.old_y;
         coord_ff[2] <= req_word.new_x;
         coord_ff[3] <= req_word.new_y;
         for (int i = 0; i < 4; i++) rem_ff[i] <= '0;
         bit_cnt_ff  <= '0;
      end else if (cmd.mod_step) begin
         for (int i = 0; i < 4; i++) begin
            coord_ff[i] <= {coord_ff[i][6:0], 1'b0};
            rem_ff[i]   <= rem_in[i];
         end
         bit_cnt_ff <= bit_cnt_ff + 3'd1;
      end
   end

   // neighborhood walk
   logic [1:0] nb_dx_ff, nb_dy_ff;
   logic [SIDE_W-1:0] nb_x, nb_y;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         nb_dx_ff <= '0;
         nb_dy_ff <= '0;
      end else if (cmd.nb_rd) begin
         if (nb_dx_ff == 2'd2) begin
            nb_dx_ff <= '0;
            nb_dy_ff <= nb_dy_ff + 2'd1;
         end else begin
            nb_dx_ff <= nb_dx_ff + 2'd1;
         end
      end
   end

   always_comb begin
      unique case (nb_dx_ff)
         2'd0:    nb_x = (rem_ff[2] == '0) ? side_m1 : rem_ff[2] - SIDE_W'(1);
         2'd1:    nb_x = rem_ff[2];
         default: nb_x = (rem_ff[2] == side_m1) ? '0 : rem_ff[2] + SIDE_W'(1);
      endcase
      unique case (nb_dy_ff)
         2'd0:    nb_y = (rem_ff[3] == '0) ? side_m1 : rem_ff[3] - SIDE_W'(1);
         2'd1:    nb_y = rem_ff[3];
         default: nb_y = (rem_ff[3] == side_m1) ? '0 : rem_ff[3] + SIDE_W'(1);
      endcase
   end

   // count memory
   logic [ADDR_W-1:0]     clr_ff;
   logic [ADDR_W-1:0]     mem_addr;
   logic [SIDE_W-1:0]     sel_x, sel_y;
   logic [2*SIDE_W-1:0]   prod;
   logic [COUNT_BITS-1:0] mem [CELLS];
   logic [COUNT_BITS-1:0] rd_ff, wdata;

   always_comb begin
      unique case (cmd.addr_sel)
         ADDR_OLD: begin
            sel_x = rem_ff[0];
            sel_y = rem_ff[1];
         end
         ADDR_NEW: begin
            sel_x = rem_ff[2];
            sel_y = rem_ff[3];
         end
         default: begin
            sel_x = nb_x;
            sel_y = nb_y;
         end
      endcase
      prod = sel_y * side;
      if (cmd.addr_sel == ADDR_CLEAR) mem_addr = clr_ff;
      else mem_addr = ADDR_W'(prod + (2*SIDE_W)'(sel_x));
      unique case (cmd.wr_sel)
         WR_DEC:  wdata = (rd_ff == '0) ? rd_ff : rd_ff - COUNT_BITS'(1);
         WR_INC:  wdata = (rd_ff == COUNT_MAX) ? rd_ff : rd_ff + COUNT_BITS'(1);
         default: wdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_we) mem[mem_addr] <= wdata;
      rd_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clr_step) clr_ff <= clr_ff + ADDR_W'(1);
   end

   // capped neighborhood sum, taken from the registered read of each address
   logic             nb_pend_ff;
   logic [CAP_W-1:0] sum_ff;
   logic [TOT_W-1:0] tot;

   assign tot = TOT_W'(rd_ff) + TOT_W'(sum_ff);

   always_ff @(posedge clock) begin
      if (reset) nb_pend_ff <= 1'b0;
      else nb_pend_ff <= cmd.nb_rd;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) sum_ff <= '0;
      else if (nb_pend_ff) begin
         if (tot > TOT_W'(NEIGHBOR_CAP)) sum_ff <= CAP_W'(NEIGHBOR_CAP);
         else sum_ff <= CAP_W'(tot);
      end
   end

   // status update
   rsp_word_type res_ff, res_in;

   always_comb begin
      logic [1:0]  st;
      logic [15:0] t;
      logic        expo;
      st   = req_ff.status;
      t    = req_ff.days_in_status;
      expo = 1'b0;
      if (st == ST_S && sum_ff != '0 && req_ff.draw_u < THRESH_TAB[8'(sum_ff)]) begin
         st   = ST_E;
         t    = '0;
         expo = 1'b1;
      end
      if (st == ST_E && t >= req_ff.dur_exposed) begin
         st = ST_I;
         t  = '0;
      end else if (st == ST_I && t >= req_ff.dur_infected) begin
         st = ST_R;
         t  = '0;
      end else if (st == ST_R && t >= req_ff.dur_recovered) begin
         st = ST_S;
         t  = '0;
      end
      if (t != 16'hFFFF) t = t + 16'd1;
      res_in.next_status     = st;
      res_in.next_time       = t;
      res_in.infected_nearby = 6'(sum_ff);
      res_in.got_exposed     = expo;
      if (req_ff.cmd == CMD_PLACE) begin
         res_in = '0;
         res_in.next_status = ST_I;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) res_ff <= res_in;
   end

   // output register
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.out_load) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) rsp_word_ff <= res_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      stat.clr_last  = (clr_ff == ADDR_W'(CELLS - 1));
      stat.mod_last  = (bit_cnt_ff == 3'd7);
      stat.nb_last   = (nb_dx_ff == 2'd2) && (nb_dy_ff == 2'd2);
      stat.is_place  = (req_ff.cmd == CMD_PLACE);
      stat.status_in = req_ff.status;
      stat.next_inf  = (res_in.next_status == ST_I);
      stat.out_free  = !rsp_valid_ff || !rsp_stall;
   end

endmodule
`default_nettype wire
